// File: hdl/rcsd_pkg.sv
// Shared types and constants of the RC stick dead-zone and switch decoder.
`timescale 1ns / 1ps

package rcsd_pkg;

    localparam int DZ_W      = 14;
    localparam int GAIN_W    = 18;
    localparam int THRESH_W  = 12;
    localparam int STICK_W   = 16;
    localparam int FRAC_BITS = 14;
    localparam int FLAG_COUNT = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE        = 3'd0,
        REG_DEAD_ZONE_GAIN   = 3'd1,
        REG_MODE_THRESHOLD   = 3'd2,
        REG_GEAR_THRESHOLD   = 3'd3,
        REG_REBOOT_THRESHOLD = 3'd4
    } cfg_reg_t;

    localparam logic [DZ_W-1:0]     DEAD_ZONE_RST   = 14'd4096;
    localparam logic [GAIN_W-1:0]   GAIN_RST        = 18'd21845;
    localparam logic [THRESH_W-1:0] MODE_THR_RST    = 12'd1750;
    localparam logic [THRESH_W-1:0] GEAR_THR_RST    = 12'd1750;
    localparam logic [THRESH_W-1:0] REBOOT_THR_RST  = 12'd1500;
    localparam logic [THRESH_W-1:0] RANGE_MAX_RAW   = 12'd2100;

    // Normalization: ch = floor((raw * 4096 + 62) / 125) - 49152.
    // The division by 125 is a multiply by ceil(2^35 / 125) and a shift.
    localparam int RAW_SHIFT    = 12;
    localparam int RECIP_BIAS   = 62;
    localparam int RECIP_W      = 29;
    localparam int RECIP_SHIFT  = 35;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd274877907;
    localparam int CENTER_Q     = 49152;
    localparam int ROUND_HALF   = 8192;
    localparam int STICK_MAX    = 32767;
    localparam int STICK_NEG_MAG = 32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DZ,
        ST_GAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic ld_recip;
        logic ld_dz;
        logic ld_gain;
    } lane_ctrl_t;

    typedef struct packed {
        logic range_ok;
        logic reboot_toggled;
        logic entered_command;
        logic command_mode;
        logic entered_hover;
        logic hover_mode;
    } sw_flags_t;

endpackage

// File: hdl/rcsd_lane.sv
// One stick lane: normalization, dead zone, gain rescale and saturation.
`timescale 1ns / 1ps

module rcsd_lane #(
    parameter int RAW_BITS = 12
) (
    input  logic                           aclk,
    input  rcsd_pkg::lane_ctrl_t           ctrl,
    input  logic [RAW_BITS-1:0]            raw,
    input  logic [rcsd_pkg::DZ_W-1:0]      dz_half,
    input  logic [rcsd_pkg::GAIN_W-1:0]    gain,
    output logic [rcsd_pkg::STICK_W-1:0]   stick_out
);
    import rcsd_pkg::*;

    localparam int YW = RAW_BITS + RAW_SHIFT;
    localparam int PW = YW + RECIP_W;
    localparam int QW = PW - RECIP_SHIFT;
    localparam int CW = QW + 1;
    localparam int MW = RAW_BITS + 6;
    localparam int GW = MW + GAIN_W;
    localparam int RW = GW + 1;
    localparam int TW = RW - FRAC_BITS;

    logic [YW-1:0]        y;
    logic [PW-1:0]        recip_prod_reg;
    logic [QW-1:0]        q;
    logic signed [CW-1:0] ch;
    logic signed [CW-1:0] dz_s;
    logic [MW-1:0]        mag_next;
    logic [MW-1:0]        mag_reg;
    logic                 neg_next;
    logic                 neg_reg;
    logic [GW-1:0]        gain_prod_reg;
    logic [RW-1:0]        rnd;
    logic [TW-1:0]        mag_out;

    assign y = {raw, {RAW_SHIFT{1'b0}}} + YW'(RECIP_BIAS);
    assign q = recip_prod_reg[RECIP_SHIFT +: QW];
    assign ch = signed'({1'b0, q}) - CW'(CENTER_Q);
    assign dz_s = signed'(CW'(dz_half));

    always_comb begin
        mag_next = '0;
        neg_next = 1'b0;
        if (ch > dz_s) begin
            mag_next = MW'(ch - dz_s);
        end else if (ch < -dz_s) begin
            mag_next = MW'(-ch - dz_s);
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_recip) begin
            recip_prod_reg <= PW'(y) * PW'(RECIP_MUL);
        end
        if (ctrl.ld_dz) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (ctrl.ld_gain) begin
            gain_prod_reg <= GW'(mag_reg) * GW'(gain);
        end
    end

    assign rnd = RW'(gain_prod_reg) + RW'(ROUND_HALF);
    assign mag_out = rnd[RW-1:FRAC_BITS];

    always_comb begin
        if (neg_reg) begin
            if (mag_out > TW'(STICK_NEG_MAG)) begin
                stick_out = STICK_W'(STICK_NEG_MAG);
            end else begin
                stick_out = STICK_W'(0) - mag_out[STICK_W-1:0];
            end
        end else begin
            if (mag_out > TW'(STICK_MAX)) begin
                stick_out = STICK_W'(STICK_MAX);
            end else begin
                stick_out = mag_out[STICK_W-1:0];
            end
        end
    end

endmodule

// File: hdl/rcsd_switch.sv
// Mode, gear and reboot switch decoding with edge detection and held state.
`timescale 1ns / 1ps

module rcsd_switch #(
    parameter int RAW_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [RAW_BITS-1:0]            mode_raw,
    input  logic [RAW_BITS-1:0]            gear_raw,
    input  logic [RAW_BITS-1:0]            reboot_raw,
    input  logic [rcsd_pkg::THRESH_W-1:0]  mode_threshold,
    input  logic [rcsd_pkg::THRESH_W-1:0]  gear_threshold,
    input  logic [rcsd_pkg::THRESH_W-1:0]  reboot_threshold,
    output rcsd_pkg::sw_flags_t            flags
);
    import rcsd_pkg::*;

    localparam int CW = (RAW_BITS > THRESH_W) ? RAW_BITS : THRESH_W;

    logic [RAW_BITS-1:0] prev_mode_reg;
    logic [RAW_BITS-1:0] prev_gear_reg;
    logic [RAW_BITS-1:0] prev_reboot_reg;
    logic                seeded_reg;
    logic                command_reg;
    logic                command_next;
    logic                entered_cmd_reg;
    logic                entered_cmd_next;
    sw_flags_t           flags_reg;
    sw_flags_t           flags_next;

    logic [CW-1:0] mode_c, gear_c, reboot_c;
    logic [CW-1:0] pmode_c, pgear_c, preboot_c;
    logic [CW-1:0] mth_c, gth_c, rth_c;
    logic          hover;

    assign mode_c    = CW'(mode_raw);
    assign gear_c    = CW'(gear_raw);
    assign reboot_c  = CW'(reboot_raw);
    assign pmode_c   = seeded_reg ? CW'(prev_mode_reg) : mode_c;
    assign pgear_c   = seeded_reg ? CW'(prev_gear_reg) : gear_c;
    assign preboot_c = seeded_reg ? CW'(prev_reboot_reg) : reboot_c;
    assign mth_c     = CW'(mode_threshold);
    assign gth_c     = CW'(gear_threshold);
    assign rth_c     = CW'(reboot_threshold);
    assign hover     = mode_c > mth_c;

    always_comb begin
        command_next     = command_reg;
        entered_cmd_next = entered_cmd_reg;
        if (hover) begin
            if (pgear_c < gth_c && gear_c > gth_c) begin
                entered_cmd_next = 1'b1;
            end else if (gear_c < gth_c) begin
                entered_cmd_next = 1'b0;
            end
            command_next = gear_c > gth_c;
        end
        flags_next.hover_mode      = hover;
        flags_next.entered_hover   = (pmode_c < mth_c) && hover;
        flags_next.command_mode    = command_next;
        flags_next.entered_command = entered_cmd_next;
        flags_next.reboot_toggled  = !hover && !command_next &&
                                     (preboot_c < rth_c) && (reboot_c > rth_c);
        flags_next.range_ok        = (mode_c <= CW'(RANGE_MAX_RAW)) &&
                                     (gear_c <= CW'(RANGE_MAX_RAW)) &&
                                     (reboot_c <= CW'(RANGE_MAX_RAW));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg      <= 1'b0;
            command_reg     <= 1'b1;
            entered_cmd_reg <= 1'b0;
        end else if (accept) begin
            seeded_reg      <= 1'b1;
            command_reg     <= command_next;
            entered_cmd_reg <= entered_cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_mode_reg   <= mode_raw;
            prev_gear_reg   <= gear_raw;
            prev_reboot_reg <= reboot_raw;
            flags_reg       <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// File: hdl/rc_stick_deadzone_switch_decoder.sv
// Top level of the RC stick dead-zone and switch decoder.
//
//  Channel  Direction  Contents of a beat
//  s_       in         one RC frame: STICK_COUNT stick widths, mode, gear, reboot
//  m_       out        conditioned sticks in Q2.14 and seven switch/status flags
//  cfg_     in         register write: dead zone, gain, three switch thresholds
//
// An accepted frame passes through the reciprocal multiply, the dead-zone subtract
// and the gain multiply registers of every stick lane and then into the output
// register; a new frame is accepted only after the current one has been loaded
// into the output register.
// A finished result waits in the output register while the next frame is taken;
// the lanes hold in their last stage while the output register is still full.
// Reset is synchronous and active low and restores the register defaults.
`timescale 1ns / 1ps

module rc_stick_deadzone_switch_decoder #(
    parameter int STICK_COUNT = 4,
    parameter int RAW_BITS    = 12,
    localparam int IN_BITS    = (STICK_COUNT + 3) * RAW_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = STICK_COUNT * rcsd_pkg::STICK_W + rcsd_pkg::FLAG_COUNT,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // stick0_raw .. stickN_raw, mode_raw, gear_raw, reboot_raw
    input  logic [IN_W-1:0]                  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // stick0_out .. stickN_out, hover_mode, entered_hover, command_mode,
    // entered_command, reboot_toggled, range_ok, sticks_centered
    output logic [OUT_W-1:0]                 m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [rcsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcsd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rcsd_pkg::*;

    localparam int STICKS_W = STICK_COUNT * STICK_W;

    logic [DZ_W-1:0]     dz_half_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [THRESH_W-1:0] mode_thr_reg;
    logic [THRESH_W-1:0] gear_thr_reg;
    logic [THRESH_W-1:0] reboot_thr_reg;

    state_t      state_reg;
    state_t      state_next;
    lane_ctrl_t  lane_ctrl;
    logic        out_load;
    logic        accept;
    sw_flags_t   flags;

    logic [STICKS_W-1:0] sticks;
    logic                centered;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [OUT_W-1:0]    m_tdata_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_half_reg    <= DEAD_ZONE_RST;
            gain_reg       <= GAIN_RST;
            mode_thr_reg   <= MODE_THR_RST;
            gear_thr_reg   <= GEAR_THR_RST;
            reboot_thr_reg <= REBOOT_THR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEAD_ZONE:        dz_half_reg    <= cfg_wdata[DZ_W-1:0];
                REG_DEAD_ZONE_GAIN:   gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_MODE_THRESHOLD:   mode_thr_reg   <= cfg_wdata[THRESH_W-1:0];
                REG_GEAR_THRESHOLD:   gear_thr_reg   <= cfg_wdata[THRESH_W-1:0];
                REG_REBOOT_THRESHOLD: reboot_thr_reg <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lane_ctrl  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    lane_ctrl.ld_recip = 1'b1;
                    state_next = ST_DZ;
                end
            end
            ST_DZ: begin
                lane_ctrl.ld_dz = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                lane_ctrl.ld_gain = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    for (genvar i = 0; i < STICK_COUNT; i++) begin : g_lane
        rcsd_lane #(
            .RAW_BITS (RAW_BITS)
        ) u_lane (
            .aclk      (aclk),
            .ctrl      (lane_ctrl),
            .raw       (s_tdata[i*RAW_BITS +: RAW_BITS]),
            .dz_half   (dz_half_reg),
            .gain      (gain_reg),
            .stick_out (sticks[i*STICK_W +: STICK_W])
        );
    end

    rcsd_switch #(
        .RAW_BITS (RAW_BITS)
    ) u_switch (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .mode_raw         (s_tdata[STICK_COUNT*RAW_BITS +: RAW_BITS]),
        .gear_raw         (s_tdata[(STICK_COUNT+1)*RAW_BITS +: RAW_BITS]),
        .reboot_raw       (s_tdata[(STICK_COUNT+2)*RAW_BITS +: RAW_BITS]),
        .mode_threshold   (mode_thr_reg),
        .gear_threshold   (gear_thr_reg),
        .reboot_threshold (reboot_thr_reg),
        .flags            (flags)
    );

    assign centered = (sticks == '0);

    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[STICKS_W-1:0] = sticks;
        m_tdata_next[STICKS_W + 0] = flags.hover_mode;
        m_tdata_next[STICKS_W + 1] = flags.entered_hover;
        m_tdata_next[STICKS_W + 2] = flags.command_mode;
        m_tdata_next[STICKS_W + 3] = flags.entered_command;
        m_tdata_next[STICKS_W + 4] = flags.reboot_toggled;
        m_tdata_next[STICKS_W + 5] = flags.range_ok;
        m_tdata_next[STICKS_W + 6] = centered;
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_DZ)
        else $error("Accepted frame did not enter the dead-zone stage.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("Result appeared without passing the output stage.");

    a_centered_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[STICKS_W + 6] == (m_tdata[STICKS_W-1:0] == '0))
        else $error("Centered flag disagrees with the stick values.");

    a_hover_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[STICKS_W + 1] && !m_tdata[STICKS_W + 0]))
        else $error("Hover edge reported while not in hover.");

    a_reboot_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STICKS_W + 4] |->
            !m_tdata[STICKS_W + 0] && !m_tdata[STICKS_W + 2])
        else $error("Reboot toggle reported in hover or command mode.");

endmodule

// File: bench/rcsd_frame_checker.sv
// Frame checker for the RC stick decoder: predicts every result beat and compares it.
`timescale 1ns / 1ps

module rcsd_frame_checker #(
    parameter int N_STICK  = 4,
    parameter int RAW_BITS = 12,
    localparam int N_CHAN   = N_STICK + 3,
    localparam int IN_BITS  = N_CHAN * RAW_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = N_STICK * 16 + 7,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [IN_W-1:0]                     s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [OUT_W-1:0]                    m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [rcsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  errors,
    output int                                  waiting,
    output int                                  frames,
    output int                                  hover_entries,
    output int                                  reboot_toggles,
    output int                                  saturated
);
    import rcsd_pkg::*;

    localparam longint CENTER_US   = 1500;
    localparam longint SPAN_US     = 500;
    localparam longint ONE_Q14     = 16384;
    localparam longint HALF_LSB_Q  = 8192;
    localparam longint POS_LIMIT   = 32767;
    localparam longint NEG_LIMIT   = 32768;
    localparam int     RANGE_LIMIT = 2100;

    typedef struct packed {
        logic                            centered;
        sw_flags_t                       flags;
        logic [N_STICK-1:0][STICK_W-1:0] sticks;
    } frame_result_t;

    logic [DZ_W-1:0]     dz_q;
    logic [GAIN_W-1:0]   gain_q;
    logic [THRESH_W-1:0] mode_thr, gear_thr, reboot_thr;
    logic [RAW_BITS-1:0] prior_mode, prior_gear, prior_reboot;
    logic                seeded, cmd_flag, cmd_entry_flag;

    frame_result_t pending_results[$];
    int fail_n = 0, frame_n = 0, hover_n = 0, toggle_n = 0, sat_n = 0;

    function automatic logic signed [STICK_W-1:0] shape_stick(input logic [RAW_BITS-1:0] raw);
        longint norm, excess, mag, dz;
        logic   neg;
        dz   = longint'(dz_q);
        norm = (longint'(raw) - CENTER_US) * ONE_Q14 + SPAN_US / 2;
        if (norm >= 0) begin
            norm = norm / SPAN_US;
        end else begin
            norm = -((-norm + SPAN_US - 1) / SPAN_US);
        end
        if (norm > dz) begin
            excess = norm - dz;
            neg    = 1'b0;
        end else if (norm < -dz) begin
            excess = -(norm + dz);
            neg    = 1'b1;
        end else begin
            return '0;
        end
        mag = (excess * longint'(gain_q) + HALF_LSB_Q) >>> FRAC_BITS;
        if (neg) begin
            return (mag > NEG_LIMIT) ? STICK_W'(-NEG_LIMIT) : STICK_W'(-mag);
        end
        return (mag > POS_LIMIT) ? STICK_W'(POS_LIMIT) : STICK_W'(mag);
    endfunction

    function automatic frame_result_t decode_frame(input logic [N_CHAN-1:0][RAW_BITS-1:0] ch);
        frame_result_t       r;
        logic [RAW_BITS-1:0] mode_w, gear_w, reboot_w;
        logic                hover;
        r        = '0;
        mode_w   = ch[N_STICK];
        gear_w   = ch[N_STICK+1];
        reboot_w = ch[N_STICK+2];
        for (int i = 0; i < N_STICK; i++) begin
            r.sticks[i] = shape_stick(ch[i]);
        end
        r.centered = (r.sticks == '0);
        r.flags.range_ok = (mode_w <= RANGE_LIMIT) && (gear_w <= RANGE_LIMIT) &&
                           (reboot_w <= RANGE_LIMIT);
        if (!seeded) begin
            seeded       = 1'b1;
            prior_mode   = mode_w;
            prior_gear   = gear_w;
            prior_reboot = reboot_w;
        end
        hover = mode_w > mode_thr;
        r.flags.entered_hover = (prior_mode < mode_thr) && hover;
        if (hover) begin
            if (prior_gear < gear_thr && gear_w > gear_thr) begin
                cmd_entry_flag = 1'b1;
            end else if (gear_w < gear_thr) begin
                cmd_entry_flag = 1'b0;
            end
            cmd_flag = gear_w > gear_thr;
        end
        r.flags.reboot_toggled = !hover && !cmd_flag && (prior_reboot < reboot_thr) &&
                                 (reboot_w > reboot_thr);
        prior_mode   = mode_w;
        prior_gear   = gear_w;
        prior_reboot = reboot_w;
        r.flags.hover_mode      = hover;
        r.flags.command_mode    = cmd_flag;
        r.flags.entered_command = cmd_entry_flag;
        return r;
    endfunction

    function automatic int flag_diff(input string name, input logic want, input logic got);
        if (got === want) return 0;
        $error("%s: expected %0b, got %0b", name, want, got);
        return 1;
    endfunction

    function automatic int compare_result(input frame_result_t want, input frame_result_t got);
        int bad;
        bad = 0;
        for (int i = 0; i < N_STICK; i++) begin
            if (got.sticks[i] !== want.sticks[i]) begin
                $error("stick%0d_out: expected %0d, got %0d", i,
                       $signed(want.sticks[i]), $signed(got.sticks[i]));
                bad++;
            end
        end
        bad += flag_diff("hover_mode", want.flags.hover_mode, got.flags.hover_mode);
        bad += flag_diff("entered_hover", want.flags.entered_hover, got.flags.entered_hover);
        bad += flag_diff("command_mode", want.flags.command_mode, got.flags.command_mode);
        bad += flag_diff("entered_command", want.flags.entered_command,
                         got.flags.entered_command);
        bad += flag_diff("reboot_toggled", want.flags.reboot_toggled,
                         got.flags.reboot_toggled);
        bad += flag_diff("range_ok", want.flags.range_ok, got.flags.range_ok);
        bad += flag_diff("sticks_centered", want.centered, got.centered);
        return bad;
    endfunction

    always @(posedge aclk) begin
        frame_result_t want, got;
        if (!aresetn) begin
            dz_q           = 14'd4096;
            gain_q         = 18'd21845;
            mode_thr       = 12'd1750;
            gear_thr       = 12'd1750;
            reboot_thr     = 12'd1500;
            prior_mode     = '0;
            prior_gear     = '0;
            prior_reboot   = '0;
            seeded         = 1'b0;
            cmd_flag       = 1'b1;
            cmd_entry_flag = 1'b0;
            pending_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEAD_ZONE:        dz_q       = cfg_wdata[DZ_W-1:0];
                    REG_DEAD_ZONE_GAIN:   gain_q     = cfg_wdata[GAIN_W-1:0];
                    REG_MODE_THRESHOLD:   mode_thr   = cfg_wdata[THRESH_W-1:0];
                    REG_GEAR_THRESHOLD:   gear_thr   = cfg_wdata[THRESH_W-1:0];
                    REG_REBOOT_THRESHOLD: reboot_thr = cfg_wdata[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = decode_frame(s_tdata[IN_BITS-1:0]);
                pending_results.push_back(want);
                frame_n++;
                hover_n  += int'(want.flags.entered_hover);
                toggle_n += int'(want.flags.reboot_toggled);
                for (int i = 0; i < N_STICK; i++) begin
                    if (want.sticks[i] == 16'h7FFF || want.sticks[i] == 16'h8000) sat_n++;
                end
            end
            if (m_tvalid && m_tready) begin
                got = frame_result_t'(m_tdata[OUT_BITS-1:0]);
                if (pending_results.size() == 0) begin
                    $error("result beat arrived with no frame outstanding");
                    fail_n++;
                end else begin
                    want = pending_results.pop_front();
                    fail_n += compare_result(want, got);
                end
            end
        end
        errors         <= fail_n;
        waiting        <= pending_results.size();
        frames         <= frame_n;
        hover_entries  <= hover_n;
        reboot_toggles <= toggle_n;
        saturated      <= sat_n;
    end

endmodule

// File: bench/tb_rc_stick_deadzone_switch_decoder.sv
// Testbench top for the RC stick decoder: reset, register phases, directed and random frames.
`timescale 1ns / 1ps

module tb_rc_stick_deadzone_switch_decoder;
    import rcsd_pkg::*;

    localparam int N_STICK         = 4;
    localparam int RAW_W           = 12;
    localparam int N_CHAN          = N_STICK + 3;
    localparam int IN_W            = ((N_CHAN * RAW_W + 7) / 8) * 8;
    localparam int OUT_W           = ((N_STICK * 16 + 7 + 7) / 8) * 8;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int IDLE_PCT        = 27;
    localparam int RAW_MAX         = (1 << RAW_W) - 1;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(REG_REBOOT_THRESHOLD + 1);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  calm = 1'b0;
    logic [RAW_W-1:0]      mode_thr_now = 12'd1750, gear_thr_now = 12'd1750;
    logic [RAW_W-1:0]      reboot_thr_now = 12'd1500;
    logic [RAW_W-1:0]      mode_hold, gear_hold, reboot_hold;
    int                    settings_used;
    int                    errors, waiting, frames, hover_entries, reboot_toggles, saturated;

    rc_stick_deadzone_switch_decoder #(
        .STICK_COUNT (N_STICK),
        .RAW_BITS    (RAW_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rcsd_frame_checker #(
        .N_STICK  (N_STICK),
        .RAW_BITS (RAW_W)
    ) frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .errors         (errors),
        .waiting        (waiting),
        .frames         (frames),
        .hover_entries  (hover_entries),
        .reboot_toggles (reboot_toggles),
        .saturated      (saturated)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MODE_THRESHOLD:   mode_thr_now   = val[RAW_W-1:0];
            REG_GEAR_THRESHOLD:   gear_thr_now   = val[RAW_W-1:0];
            REG_REBOOT_THRESHOLD: reboot_thr_now = val[RAW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(input logic [N_CHAN-1:0][RAW_W-1:0] chans);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= IN_W'(chans);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_item(input logic [RAW_W-1:0] s0, s1, s2, s3, mode, gear, reboot);
        send_frame({reboot, gear, mode, s3, s2, s1, s0});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (waiting != 0);
    endtask

    function automatic logic [RAW_W-1:0] pick_stick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return RAW_W'($urandom_range(0, RAW_MAX));
        if (r < 70) return RAW_W'($urandom_range(1300, 1700));
        if (r < 85) return RAW_W'($urandom_range(1000, 2000));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return RAW_W'(RAW_MAX);
            2:       return 12'd1000;
            default: return 12'd2000;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_switch(input logic [RAW_W-1:0] thr,
                                                     input logic [RAW_W-1:0] held);
        int r, ceiling;
        r = $urandom_range(0, 99);
        ceiling = (int'(thr) + 600 > RAW_MAX) ? RAW_MAX : int'(thr) + 600;
        if (r < 55) return held;
        if (r < 72) return (thr == '0) ? thr : RAW_W'($urandom_range(0, int'(thr) - 1));
        if (r < 89) return (int'(thr) == RAW_MAX) ? thr :
                           RAW_W'($urandom_range(int'(thr) + 1, ceiling));
        if (r < 94) return thr;
        return RAW_W'($urandom_range(0, RAW_MAX));
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain();
            mode_hold   = pick_switch(mode_thr_now, mode_hold);
            gear_hold   = pick_switch(gear_thr_now, gear_hold);
            reboot_hold = pick_switch(reboot_thr_now, reboot_hold);
            send_item(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                      mode_hold, gear_hold, reboot_hold);
        end
        drain();
        settings_used++;
    endtask

    task automatic write_spare();
        write_reg(FIRST_SPARE_IDX + CFG_IDX_W'($urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
    endtask

    initial begin
        settings_used = 1;
        mode_hold     = 12'd1000;
        gear_hold     = 12'd1000;
        reboot_hold   = 12'd1000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(1500, 1500, 1500, 1500, 1000, 1000, 1000);
        send_item(0, 4095, 1625, 1375, 2000, 1000, 1000);
        send_item(1626, 1374, 4095, 0, 2000, 2000, 1000);
        send_item(1500, 1500, 1500, 1500, 2000, 1750, 1000);
        send_item(2730, 1365, 1500, 1500, 2000, 1000, 1000);
        send_item(1500, 1500, 1500, 1500, 1750, 1000, 1000);
        send_item(1500, 1500, 1500, 1500, 1000, 1000, 1500);
        send_item(1500, 1500, 1500, 1500, 1000, 1000, 2000);
        send_item(1500, 1500, 1500, 1500, 1000, 1000, 1000);
        send_item(1500, 1500, 1500, 1500, 1000, 1000, 2000);
        send_item(1500, 1500, 1500, 1500, 1000, 1000, 1000);
        send_item(1500, 1500, 1500, 1500, 2100, 2100, 2100);
        send_item(4095, 4095, 4095, 4095, 2101, 4095, 0);
        send_item(0, 0, 0, 0, 0, 0, 4095);
        send_item(1365, 2730, 1000, 2000, 4095, 2101, 2100);
        send_item(1500, 1500, 1500, 1500, 0, 0, 0);
        drain();

        calm <= 1'b1;
        write_reg(REG_DEAD_ZONE, 18'd0);
        write_reg(REG_DEAD_ZONE_GAIN, 18'd16384);
        write_reg(REG_MODE_THRESHOLD, 18'd1000);
        write_reg(REG_GEAR_THRESHOLD, 18'd1200);
        write_reg(REG_REBOOT_THRESHOLD, 18'd1400);
        run_random(ITEMS_PER_PHASE);
        calm <= 1'b0;

        write_reg(REG_DEAD_ZONE, 18'd14746);
        write_reg(REG_DEAD_ZONE_GAIN, 18'd163840);
        write_reg(REG_MODE_THRESHOLD, 18'd1750);
        write_reg(REG_GEAR_THRESHOLD, 18'd1750);
        write_reg(REG_REBOOT_THRESHOLD, 18'd1500);
        run_random(ITEMS_PER_PHASE);

        write_reg(REG_DEAD_ZONE, '1);
        write_reg(REG_DEAD_ZONE_GAIN, '1);
        write_reg(REG_MODE_THRESHOLD, 18'h3F000);
        write_reg(REG_GEAR_THRESHOLD, '1);
        write_reg(REG_REBOOT_THRESHOLD, 18'h30FFF);
        write_spare();
        run_random(ITEMS_PER_PHASE);

        write_reg(REG_DEAD_ZONE, CFG_DATA_W'($urandom_range(0, 14746)));
        write_reg(REG_DEAD_ZONE_GAIN, CFG_DATA_W'($urandom_range(16384, 163840)));
        write_reg(REG_MODE_THRESHOLD, CFG_DATA_W'($urandom_range(1000, 2000)));
        write_reg(REG_GEAR_THRESHOLD, CFG_DATA_W'($urandom_range(1000, 2000)));
        write_reg(REG_REBOOT_THRESHOLD, CFG_DATA_W'($urandom_range(1000, 2000)));
        write_spare();
        write_spare();
        run_random(ITEMS_PER_PHASE);

        write_reg(REG_DEAD_ZONE, 18'd4096);
        write_reg(REG_DEAD_ZONE_GAIN, 18'd21845);
        write_reg(REG_MODE_THRESHOLD, 18'd1750);
        write_reg(REG_GEAR_THRESHOLD, 18'd1750);
        write_reg(REG_REBOOT_THRESHOLD, 18'd1500);
        run_random(ITEMS_PER_PHASE);

        repeat (8) @(posedge aclk);
        $display("Ran %0d frames under %0d register settings, directed edge cases first.",
                 frames, settings_used);
        $display("Saw %0d hover entries, %0d reboot toggles and %0d saturated sticks.",
                 hover_entries, reboot_toggles, saturated);
        if (errors == 0 && waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/rcsd_pkg.sv
hdl/rcsd_lane.sv
hdl/rcsd_switch.sv
hdl/rc_stick_deadzone_switch_decoder.sv
bench/rcsd_frame_checker.sv
bench/tb_rc_stick_deadzone_switch_decoder.sv
